/* src/mbe_pkg.sv */
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared widths, register map and the handshake types between the escape-time
// sequencer and its multiplier.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int CoordBits = 12;
  localparam int FracBits  = 58;
  localparam int IterBits  = 17;
  localparam int DataBits  = 64;
  localparam int HalfBits  = DataBits / 2;
  localparam int ProdBits  = 2 * DataBits;
  localparam int StepBits  = 63;
  localparam int MagBits   = 63;

  // APB map: one 64-bit register every 8 bytes
  localparam int RegShift   = 3;
  localparam int RegIdxBits = 3;
  localparam int AddrBits   = RegShift + RegIdxBits;

  localparam logic [RegIdxBits-1:0] RegLeftEdge = 3'd0;
  localparam logic [RegIdxBits-1:0] RegTopEdge  = 3'd1;
  localparam logic [RegIdxBits-1:0] RegStepRe   = 3'd2;
  localparam logic [RegIdxBits-1:0] RegStepIm   = 3'd3;
  localparam logic [RegIdxBits-1:0] RegMaxIter  = 3'd4;

  localparam logic [IterBits-1:0] DepthMin   = 17'd3;
  localparam logic [IterBits-1:0] DepthMax   = 17'd100000;
  localparam logic [IterBits-1:0] DepthReset = 17'd350;

  // |z|^2 escape threshold, 4.0 in Q5.58
  localparam logic [DataBits-1:0] EscapeLimit = DataBits'(4) << FracBits;

  typedef struct packed {
    logic signed [DataBits-1:0] left_edge;
    logic signed [DataBits-1:0] top_edge;
    logic [StepBits-1:0]        step_re;
    logic [StepBits-1:0]        step_im;
    logic [IterBits-1:0]        max_iterations;
  } mbe_cfg_t;

  typedef struct packed {
    logic                start;
    logic                fx;     // 1: signed fixed-point product, 0: unsigned integer product
    logic [DataBits-1:0] a;
    logic [DataBits-1:0] b;
  } mbe_mul_req_t;

  typedef struct packed {
    logic                done;
    logic [DataBits-1:0] res;
  } mbe_mul_rsp_t;

endpackage

/* src/mbe_pix_if.sv */
// ----------------------------------------------------------------------------
// mbe_pix_if
// Pixel request channel: one column/row pair per item.
// ----------------------------------------------------------------------------
interface mbe_pix_if import mbe_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic [CoordBits-1:0] pixel_col;
  logic [CoordBits-1:0] pixel_row;

  modport source (output valid, pixel_col, pixel_row, input ready);
  modport sink   (input valid, pixel_col, pixel_row, output ready);

endinterface

/* src/mbe_res_if.sv */
// ----------------------------------------------------------------------------
// mbe_res_if
// Escape-time result channel: one item per pixel.
// ----------------------------------------------------------------------------
interface mbe_res_if import mbe_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic [CoordBits-1:0] out_col;
  logic [CoordBits-1:0] out_row;
  logic [IterBits-1:0]  escape_iter;
  logic                 escaped;
  logic [MagBits-1:0]   final_mag_sq;

  modport source (output valid, out_col, out_row, escape_iter, escaped, final_mag_sq,
                  input ready);
  modport sink   (input valid, out_col, out_row, escape_iter, escaped, final_mag_sq,
                  output ready);

endinterface

/* src/mbe_mul.sv */
// ----------------------------------------------------------------------------
// mbe_mul
// Shared 64x64 multiplier built from one 32x32 multiplier, four partial
// products a request, with Q5.58 rescale or integer saturation at the end.
// ----------------------------------------------------------------------------
module mbe_mul import mbe_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  mbe_mul_req_t req_i,
  output mbe_mul_rsp_t rsp_o
);

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_ACC, M_FIN} state_e;

  state_e              state_q;
  logic [1:0]          k_q;
  logic [1:0]          pp_k_q;
  logic                pp_vld_q;
  logic                fx_q;
  logic                neg_q;
  logic                done_q;
  logic [DataBits-1:0] res_q;

  logic [DataBits-1:0] opa_q, opb_q;
  logic [DataBits-1:0] pp_q;
  logic [ProdBits-1:0] acc_q;

  logic [HalfBits-1:0] a_half, b_half;
  logic [DataBits-1:0] pp_d;
  logic [ProdBits-1:0] pp_ext;
  logic [ProdBits-1:0] shr;
  logic [DataBits-1:0] limit, clip, fin;
  logic                take;

  function automatic logic [DataBits-1:0] abs64(logic [DataBits-1:0] v);
    return v[DataBits-1] ? (~v + DataBits'(1)) : v;
  endfunction

  assign take = req_i.start && (state_q == M_IDLE);

  // partial product order: a0*b0, a0*b1, a1*b0, a1*b1
  assign a_half = k_q[1] ? opa_q[DataBits-1:HalfBits] : opa_q[HalfBits-1:0];
  assign b_half = k_q[0] ? opb_q[DataBits-1:HalfBits] : opb_q[HalfBits-1:0];
  assign pp_d   = a_half * b_half;

  always_comb begin
    unique case (pp_k_q)
      2'd0:       pp_ext = {{DataBits{1'b0}}, pp_q};
      2'd1, 2'd2: pp_ext = {{HalfBits{1'b0}}, pp_q, {HalfBits{1'b0}}};
      2'd3:       pp_ext = {pp_q, {DataBits{1'b0}}};
      default:    pp_ext = '0;
    endcase
  end

  // rescale, clip to the signed range of the result sign, restore sign
  always_comb begin
    shr   = fx_q ? (acc_q >> FracBits) : acc_q;
    limit = neg_q ? {1'b1, {(DataBits-1){1'b0}}} : {1'b0, {(DataBits-1){1'b1}}};
    clip  = (shr > {{DataBits{1'b0}}, limit}) ? limit : shr[DataBits-1:0];
    fin   = neg_q ? (~clip + DataBits'(1)) : clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= M_IDLE;
      k_q      <= '0;
      pp_vld_q <= 1'b0;
      fx_q     <= 1'b0;
      neg_q    <= 1'b0;
      done_q   <= 1'b0;
      res_q    <= '0;
    end else begin
      done_q   <= (state_q == M_FIN);
      pp_vld_q <= (state_q == M_MUL);
      unique case (state_q)
        M_IDLE: begin
          if (take) begin
            fx_q    <= req_i.fx;
            neg_q   <= req_i.fx && (req_i.a[DataBits-1] != req_i.b[DataBits-1]);
            k_q     <= '0;
            state_q <= M_MUL;
          end
        end
        M_MUL: begin
          k_q <= k_q + 2'd1;
          if (k_q == 2'd3) begin
            state_q <= M_ACC;
          end
        end
        M_ACC: begin
          state_q <= M_FIN;
        end
        M_FIN: begin
          res_q   <= fin;
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    pp_q   <= pp_d;
    pp_k_q <= k_q;
    if (take) begin
      opa_q <= req_i.fx ? abs64(req_i.a) : req_i.a;
      opb_q <= req_i.fx ? abs64(req_i.b) : req_i.b;
      acc_q <= '0;
    end else if (pp_vld_q) begin
      acc_q <= acc_q + pp_ext;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

/* src/mbe_regs.sv */
// ----------------------------------------------------------------------------
// mbe_regs
// APB register file for the view edges, pixel steps and iteration depth.
// ----------------------------------------------------------------------------
module mbe_regs import mbe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [DataBits-1:0] pwdata,
  output logic [DataBits-1:0] prdata,
  output logic                pready,
  output mbe_cfg_t            cfg_o
);

  mbe_cfg_t              cfg_q;
  logic                  wr_en;
  logic [RegIdxBits-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[AddrBits-1:RegShift];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_edge      <= '0;
      cfg_q.top_edge       <= '0;
      cfg_q.step_re        <= '0;
      cfg_q.step_im        <= '0;
      cfg_q.max_iterations <= DepthReset;
    end else if (wr_en) begin
      unique case (idx)
        RegLeftEdge: cfg_q.left_edge      <= pwdata;
        RegTopEdge:  cfg_q.top_edge       <= pwdata;
        RegStepRe:   cfg_q.step_re        <= pwdata[StepBits-1:0];
        RegStepIm:   cfg_q.step_im        <= pwdata[StepBits-1:0];
        RegMaxIter:  cfg_q.max_iterations <= pwdata[IterBits-1:0];
        default: ;  // drop writes outside the map
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegLeftEdge: prdata = cfg_q.left_edge;
      RegTopEdge:  prdata = cfg_q.top_edge;
      RegStepRe:   prdata = {{(DataBits-StepBits){1'b0}}, cfg_q.step_re};
      RegStepIm:   prdata = {{(DataBits-StepBits){1'b0}}, cfg_q.step_im};
      RegMaxIter:  prdata = {{(DataBits-IterBits){1'b0}}, cfg_q.max_iterations};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* src/mbe_core.sv */
// ----------------------------------------------------------------------------
// mbe_core
// Escape-time sequencer: forms c, runs z = z*z + c through the shared
// multiplier and holds the result item until it is taken.
// ----------------------------------------------------------------------------
module mbe_core import mbe_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  mbe_cfg_t     cfg_i,
  mbe_pix_if.sink      pix_i,
  mbe_res_if.source    res_o,
  output mbe_mul_req_t mul_req_o,
  input  mbe_mul_rsp_t mul_rsp_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_CRS, S_CRW, S_CIW, S_RI, S_RIW, S_ZR, S_ZI, S_RRW, S_IIW, S_MAG, S_OUT
  } state_e;

  state_e               state_q;
  logic [CoordBits-1:0] col_q, row_q;
  logic [IterBits-1:0]  depth_q, it_q, esc_iter_q;
  logic                 esc_q;
  logic [DataBits-1:0]  cr_q, ci_q, zr_q, zi_q, rr_q, ii_q, ri_q, t_q, u_q, mag_q;
  logic                 out_valid_q;
  logic [CoordBits-1:0] out_col_q, out_row_q;
  logic [IterBits-1:0]  out_iter_q;
  logic                 out_esc_q;
  logic [MagBits-1:0]   out_mag_q;

  logic [DataBits-1:0]  mag_d;
  logic                 escape_hit;
  logic                 out_load;

  function automatic logic [DataBits-1:0] sat_add(logic [DataBits-1:0] a,
                                                  logic [DataBits-1:0] b);
    logic [DataBits:0] s;
    s = {a[DataBits-1], a} + {b[DataBits-1], b};
    if (s[DataBits] != s[DataBits-1]) begin
      return s[DataBits] ? {1'b1, {(DataBits-1){1'b0}}} : {1'b0, {(DataBits-1){1'b1}}};
    end
    return s[DataBits-1:0];
  endfunction

  function automatic logic [DataBits-1:0] sat_sub(logic [DataBits-1:0] a,
                                                  logic [DataBits-1:0] b);
    logic [DataBits:0] s;
    s = {a[DataBits-1], a} - {b[DataBits-1], b};
    if (s[DataBits] != s[DataBits-1]) begin
      return s[DataBits] ? {1'b1, {(DataBits-1){1'b0}}} : {1'b0, {(DataBits-1){1'b1}}};
    end
    return s[DataBits-1:0];
  endfunction

  function automatic logic [IterBits-1:0] clamp_depth(logic [IterBits-1:0] v);
    if (v < DepthMin) return DepthMin;
    if (v > DepthMax) return DepthMax;
    return v;
  endfunction

  assign mag_d      = sat_add(rr_q, ii_q);
  assign escape_hit = $signed(mag_d) >= $signed(EscapeLimit);
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || res_o.ready);

  // operand select for the shared multiplier
  always_comb begin
    mul_req_o.start = 1'b0;
    mul_req_o.fx    = 1'b1;
    mul_req_o.a     = zr_q;
    mul_req_o.b     = zi_q;
    unique case (state_q)
      S_CRS: begin
        mul_req_o.start = 1'b1;
        mul_req_o.fx    = 1'b0;
        mul_req_o.a     = {{(DataBits-CoordBits){1'b0}}, col_q};
        mul_req_o.b     = {{(DataBits-StepBits){1'b0}}, cfg_i.step_re};
      end
      S_CRW: begin
        mul_req_o.start = mul_rsp_i.done;
        mul_req_o.fx    = 1'b0;
        mul_req_o.a     = {{(DataBits-CoordBits){1'b0}}, row_q};
        mul_req_o.b     = {{(DataBits-StepBits){1'b0}}, cfg_i.step_im};
      end
      S_RI: begin
        mul_req_o.start = 1'b1;
      end
      S_ZI: begin
        mul_req_o.start = 1'b1;
        mul_req_o.b     = zr_q;
      end
      S_RRW: begin
        mul_req_o.start = mul_rsp_i.done;
        mul_req_o.a     = zi_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      depth_q     <= DepthMin;
      it_q        <= '0;
      esc_iter_q  <= '0;
      esc_q       <= 1'b0;
      cr_q        <= '0;
      ci_q        <= '0;
      zr_q        <= '0;
      zi_q        <= '0;
      rr_q        <= '0;
      ii_q        <= '0;
      ri_q        <= '0;
      t_q         <= '0;
      u_q         <= '0;
      mag_q       <= '0;
      out_valid_q <= 1'b0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_iter_q  <= '0;
      out_esc_q   <= 1'b0;
      out_mag_q   <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (pix_i.valid) begin
            col_q   <= pix_i.pixel_col;
            row_q   <= pix_i.pixel_row;
            depth_q <= clamp_depth(cfg_i.max_iterations);
            state_q <= S_CRS;
          end
        end
        S_CRS: state_q <= S_CRW;
        S_CRW: begin
          if (mul_rsp_i.done) begin
            cr_q    <= sat_add(cfg_i.left_edge, mul_rsp_i.res);
            state_q <= S_CIW;
          end
        end
        S_CIW: begin
          if (mul_rsp_i.done) begin
            ci_q    <= sat_add(cfg_i.top_edge, mul_rsp_i.res);
            zr_q    <= '0;
            zi_q    <= '0;
            rr_q    <= '0;
            ii_q    <= '0;
            it_q    <= '0;
            state_q <= S_RI;
          end
        end
        S_RI: begin
          // zr^2 and zi^2 carry over from the previous magnitude
          t_q     <= sat_sub(rr_q, ii_q);
          state_q <= S_RIW;
        end
        S_RIW: begin
          if (mul_rsp_i.done) begin
            ri_q    <= mul_rsp_i.res;
            state_q <= S_ZR;
          end
        end
        S_ZR: begin
          zr_q    <= sat_add(t_q, cr_q);
          u_q     <= sat_add(ri_q, ri_q);
          state_q <= S_ZI;
        end
        S_ZI: begin
          zi_q    <= sat_add(u_q, ci_q);
          state_q <= S_RRW;
        end
        S_RRW: begin
          if (mul_rsp_i.done) begin
            rr_q    <= mul_rsp_i.res;
            state_q <= S_IIW;
          end
        end
        S_IIW: begin
          if (mul_rsp_i.done) begin
            ii_q    <= mul_rsp_i.res;
            state_q <= S_MAG;
          end
        end
        S_MAG: begin
          mag_q <= mag_d;
          if (escape_hit) begin
            esc_q      <= 1'b1;
            esc_iter_q <= it_q;
            state_q    <= S_OUT;
          end else if (it_q == depth_q - IterBits'(1)) begin
            esc_q      <= 1'b0;
            esc_iter_q <= '0;
            state_q    <= S_OUT;
          end else begin
            it_q    <= it_q + IterBits'(1);
            state_q <= S_RI;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            out_col_q   <= col_q;
            out_row_q   <= row_q;
            out_iter_q  <= esc_iter_q;
            out_esc_q   <= esc_q;
            out_mag_q   <= mag_q[MagBits-1:0];
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign pix_i.ready        = (state_q == S_IDLE);
  assign res_o.valid        = out_valid_q;
  assign res_o.out_col      = out_col_q;
  assign res_o.out_row      = out_row_q;
  assign res_o.escape_iter  = out_iter_q;
  assign res_o.escaped      = out_esc_q;
  assign res_o.final_mag_sq = out_mag_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready |=> !pix_i.ready)
    else $error("pixel channel ready right after an accepted item");

  a_done_while_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp_i.done |-> (state_q == S_CRW || state_q == S_CIW || state_q == S_RIW ||
                        state_q == S_RRW || state_q == S_IIW))
    else $error("multiplier result arrived outside a wait state");

  a_iter_in_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MAG |-> it_q < depth_q)
    else $error("iteration count ran past the depth limit");

  a_no_escape_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.escaped |-> res_o.escape_iter == '0)
    else $error("non-escaped item carries a nonzero escape iteration");

endmodule

/* src/mandelbrot_escape_time_top.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_top
// Mandelbrot escape-time engine for one pixel at a time, Q5.58 arithmetic.
// ----------------------------------------------------------------------------
// Usage:
//   Program left_edge, top_edge, step_re, step_im and max_iterations over the
//   APB port (64-bit registers at byte offsets 0, 8, 16, 24, 32) while idle.
//   Send pixel column/row items on pix_i; each returns one item on res_o with
//   the pixel echoed, the escape iteration, the escaped flag and |z|^2.
// Multiplier sharing:
//   All products go through one 32x32 multiplier, four partial products plus
//   rescale per 64-bit product. Forming c takes 2 products, each iteration 3
//   (zr*zi, zr^2, zi^2), and an item runs at most the clamped depth of
//   iterations. pix_i.ready is low while an item is in flight.
// Reset:
//   rst_ni clears the sequencer and output valid and loads the register reset
//   values (depth 350, all else zero).
// Stall:
//   The result sits in an output register; a new pixel is taken while it waits,
//   and the engine holds its next result until res_o is free.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_top import mbe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [DataBits-1:0] pwdata,
  output logic [DataBits-1:0] prdata,
  output logic                pready,
  mbe_pix_if.sink             pix_i,
  mbe_res_if.source           res_o
);

  mbe_cfg_t     cfg;
  mbe_mul_req_t mul_req;
  mbe_mul_rsp_t mul_rsp;

  mbe_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mbe_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  mbe_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .pix_i     (pix_i),
    .res_o     (res_o),
    .mul_req_o (mul_req),
    .mul_rsp_i (mul_rsp)
  );

endmodule
